@@ rtl/tmcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tmcw_pkg: shared types and constants of the text-mode console writer
// Screen geometry, character codes, command codes, sequencer states and the
// screen store port bundle.
// ----------------------------------------------------------------------------
package tmcw_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   // payload field widths
   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 16;

   // character codes and attributes
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'h0F;

   // sweep limits
   localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELLS - COLUMNS);

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUT       = 3'd0,
      CMD_PUT_AT    = 3'd1,
      CMD_BACKSPACE = 3'd2,
      CMD_CLEAR     = 3'd3,
      CMD_READ      = 3'd4
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_ZERO,
      ST_FILL,
      ST_RESP
   } state_type;

   // screen store port bundle
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

@@ rtl/tmcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tmcw_screen_ram: screen cell store
// One write port and one read port with registered read data; character in
// the low byte, attribute in the high byte.
// ----------------------------------------------------------------------------
module tmcw_screen_ram (
   input  logic                         clock,
   input  tmcw_pkg::ram_req_type        ram_req,
   output logic [tmcw_pkg::CELL_W-1:0]  rd_data
);

   logic [tmcw_pkg::CELL_W-1:0] mem [tmcw_pkg::CELLS];
   logic [tmcw_pkg::CELL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read port, registered every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/text_mode_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// text_mode_console_writer_top: character-cell console engine
// Keeps a screen store and a cursor; puts characters, handles newline,
// backspace, scroll and clear, and reads back single cells.
//
//   channel  ports                                     direction
//   req      req_valid/ready, cmd, char_code,          in
//            column, row_index
//   rsp      rsp_valid/ready, cursor_col/row,          out
//            cell_char, cell_attr, rejected
//   csr      csr_wr_en, csr_wr_data (text attribute)   in
//
// A put, backspace or unused code runs in ST_EXEC and then hands its result
// over in ST_RESP; a cell read also passes through ST_READ. A put that scrolls
// walks the store once through the single read and write port. Clear writes
// every cell in turn. After reset a clearing pass zeroes the store before
// req_ready rises. A stalled result sits in the output register while the next
// command is taken and run; the sequencer waits to hand over its own result
// until that register is free.
// ----------------------------------------------------------------------------
module text_mode_console_writer_top (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tmcw_pkg::CMD_W-1:0]    req_cmd,
   input  logic [tmcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tmcw_pkg::COL_W-1:0]    req_column,
   input  logic [tmcw_pkg::ROW_W-1:0]    req_row_index,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tmcw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic [tmcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tmcw_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [tmcw_pkg::CHAR_W-1:0]   rsp_cell_attr,
   output logic                          rsp_rejected,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [tmcw_pkg::CHAR_W-1:0]   csr_wr_data
);

   // control state
   tmcw_pkg::state_type              state_ff, state_in;
   logic [tmcw_pkg::ADDR_W-1:0]      cnt_ff, cnt_in;
   logic [tmcw_pkg::COL_W-1:0]       cur_col_ff, cur_col_in;
   logic [tmcw_pkg::ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [tmcw_pkg::CHAR_W-1:0]      text_attr_ff;
   logic                             rsp_valid_ff, rsp_valid_in;

   // command payload
   logic [tmcw_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [tmcw_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic [tmcw_pkg::COL_W-1:0]       tgt_col_ff, tgt_col_in;
   logic [tmcw_pkg::ROW_W-1:0]       tgt_row_ff, tgt_row_in;
   logic [tmcw_pkg::CHAR_W-1:0]      res_char_ff, res_char_in;
   logic [tmcw_pkg::CHAR_W-1:0]      res_attr_ff, res_attr_in;
   logic                             res_rej_ff, res_rej_in;

   // result register
   logic [tmcw_pkg::COL_W-1:0]       out_col_ff, out_col_in;
   logic [tmcw_pkg::ROW_W-1:0]       out_row_ff, out_row_in;
   logic [tmcw_pkg::CHAR_W-1:0]      out_char_ff, out_char_in;
   logic [tmcw_pkg::CHAR_W-1:0]      out_attr_ff, out_attr_in;
   logic                             out_rej_ff, out_rej_in;

   // datapath
   tmcw_pkg::ram_req_type            ram_req;
   logic [tmcw_pkg::CELL_W-1:0]      rd_data;
   logic [tmcw_pkg::ADDR_W-1:0]      lin_addr;
   logic [tmcw_pkg::CHAR_W-1:0]      put_attr;
   logic                             in_range;
   logic                             last_row;
   logic                             row_end;

   tmcw_screen_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // cell address of the target; the one multiplier of the block
   assign lin_addr = tmcw_pkg::ADDR_W'(tmcw_pkg::ADDR_W'(tgt_row_ff)
                     * tmcw_pkg::ADDR_W'(tmcw_pkg::COLUMNS))
                     + tmcw_pkg::ADDR_W'(tgt_col_ff);

   assign put_attr = (text_attr_ff != '0) ? text_attr_ff : tmcw_pkg::DEFAULT_ATTR;
   assign in_range = ({1'b0, req_column} < 8'(tmcw_pkg::COLUMNS))
                  && ({1'b0, req_row_index} < 6'(tmcw_pkg::ROWS));
   assign last_row = (tgt_row_ff == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1));
   assign row_end  = (({1'b0, tgt_col_ff} + 8'd1) == 8'(tmcw_pkg::COLUMNS));

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= tmcw_pkg::DEFAULT_ATTR;
      end else if (csr_wr_en) begin
         text_attr_ff <= csr_wr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmcw_pkg::ST_INIT;
         cnt_ff       <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      char_ff     <= char_in;
      tgt_col_ff  <= tgt_col_in;
      tgt_row_ff  <= tgt_row_in;
      res_char_ff <= res_char_in;
      res_attr_ff <= res_attr_in;
      res_rej_ff  <= res_rej_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_char_ff <= out_char_in;
      out_attr_ff <= out_attr_in;
      out_rej_ff  <= out_rej_in;
   end

   // sequencer: next state, store port and register updates
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cmd_in       = cmd_ff;
      char_in      = char_ff;
      tgt_col_in   = tgt_col_ff;
      tgt_row_in   = tgt_row_ff;
      res_char_in  = res_char_ff;
      res_attr_in  = res_attr_ff;
      res_rej_in   = res_rej_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_char_in  = out_char_ff;
      out_attr_in  = out_attr_ff;
      out_rej_in   = out_rej_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ram_req      = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         // zero the store after reset
         tmcw_pkg::ST_INIT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt_ff;
            if (cnt_ff == tmcw_pkg::LAST_CELL) begin
               cnt_in   = '0;
               state_in = tmcw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // take a command and pick its target cell
         tmcw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in      = req_cmd;
               char_in     = req_char_code;
               res_char_in = '0;
               res_attr_in = '0;
               res_rej_in  = 1'b0;
               tgt_col_in  = req_column;
               tgt_row_in  = req_row_index;
               state_in    = tmcw_pkg::ST_EXEC;
               unique case (req_cmd)
                  tmcw_pkg::CMD_PUT: begin
                     tgt_col_in = cur_col_ff;
                     tgt_row_in = cur_row_ff;
                  end
                  tmcw_pkg::CMD_PUT_AT, tmcw_pkg::CMD_READ: begin
                     if (!in_range) begin
                        res_rej_in = 1'b1;
                        state_in   = tmcw_pkg::ST_RESP;
                     end
                  end
                  tmcw_pkg::CMD_BACKSPACE: begin
                     // step back one cell, wrapping to the previous row
                     if (cur_col_ff != '0) begin
                        tgt_col_in = cur_col_ff - 1'b1;
                        tgt_row_in = cur_row_ff;
                     end else if (cur_row_ff != '0) begin
                        tgt_col_in = tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1);
                        tgt_row_in = cur_row_ff - 1'b1;
                     end else begin
                        tgt_col_in = '0;
                        tgt_row_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // run the command on the target cell
         tmcw_pkg::ST_EXEC: begin
            state_in = tmcw_pkg::ST_RESP;
            unique case (cmd_ff)
               tmcw_pkg::CMD_PUT, tmcw_pkg::CMD_PUT_AT: begin
                  if (char_ff == tmcw_pkg::CH_NEWLINE) begin
                     cur_col_in = '0;
                     if (last_row) begin
                        cur_row_in = tgt_row_ff;
                        cnt_in     = '0;
                        state_in   = tmcw_pkg::ST_SCROLL;
                     end else begin
                        cur_row_in = tgt_row_ff + 1'b1;
                     end
                  end else if (char_ff == tmcw_pkg::CH_BACKSPACE) begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = lin_addr;
                     ram_req.wr_data = {put_attr, tmcw_pkg::CH_SPACE};
                     cur_col_in      = tgt_col_ff;
                     cur_row_in      = tgt_row_ff;
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = lin_addr;
                     ram_req.wr_data = {put_attr, char_ff};
                     if (row_end) begin
                        cur_col_in = '0;
                        if (last_row) begin
                           cur_row_in = tgt_row_ff;
                           cnt_in     = '0;
                           state_in   = tmcw_pkg::ST_SCROLL;
                        end else begin
                           cur_row_in = tgt_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = tgt_col_ff + 1'b1;
                        cur_row_in = tgt_row_ff;
                     end
                  end
               end
               tmcw_pkg::CMD_BACKSPACE: begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = lin_addr;
                  ram_req.wr_data = {put_attr, tmcw_pkg::CH_SPACE};
                  cur_col_in      = tgt_col_ff;
                  cur_row_in      = tgt_row_ff;
               end
               tmcw_pkg::CMD_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
                  cnt_in     = '0;
                  state_in   = tmcw_pkg::ST_FILL;
               end
               tmcw_pkg::CMD_READ: begin
                  ram_req.rd_addr = lin_addr;
                  state_in        = tmcw_pkg::ST_READ;
               end
               default: begin
               end
            endcase
         end

         // capture the cell read
         tmcw_pkg::ST_READ: begin
            res_char_in = rd_data[tmcw_pkg::CHAR_W-1:0];
            res_attr_in = rd_data[tmcw_pkg::CELL_W-1:tmcw_pkg::CHAR_W];
            state_in    = tmcw_pkg::ST_RESP;
         end

         // move every row up: read one row ahead, write the cell read last cycle
         tmcw_pkg::ST_SCROLL: begin
            if (cnt_ff != tmcw_pkg::SCROLL_LAST) begin
               ram_req.rd_addr = cnt_ff + tmcw_pkg::ADDR_W'(tmcw_pkg::COLUMNS);
            end
            if (cnt_ff != '0) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = cnt_ff - 1'b1;
               ram_req.wr_data = rd_data;
            end
            if (cnt_ff == tmcw_pkg::SCROLL_LAST) begin
               state_in = tmcw_pkg::ST_ZERO;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // zero the last row after a scroll
         tmcw_pkg::ST_ZERO: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt_ff;
            if (cnt_ff == tmcw_pkg::LAST_CELL) begin
               state_in = tmcw_pkg::ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // fill every cell with a space in the raw attribute
         tmcw_pkg::ST_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt_ff;
            ram_req.wr_data = {text_attr_ff, tmcw_pkg::CH_SPACE};
            if (cnt_ff == tmcw_pkg::LAST_CELL) begin
               state_in = tmcw_pkg::ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // hand the result over once the output register is free
         tmcw_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_col_in   = cur_col_ff;
               out_row_in   = cur_row_ff;
               out_char_in  = res_char_ff;
               out_attr_in  = res_attr_ff;
               out_rej_in   = res_rej_ff;
               state_in     = tmcw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tmcw_pkg::ST_IDLE;
         end
      endcase
   end

   // result ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cell_char  = out_char_ff;
   assign rsp_cell_attr  = out_attr_ff;
   assign rsp_rejected   = out_rej_ff;

endmodule
